FILE: design/sfha_pkg.sv
// Shared widths, codes and size-class helpers for the segregated-fit heap allocator.
package sfha_pkg;

	localparam int unsigned ADDR_W           = 21;
	localparam int unsigned CHUNK_W          = 21;
	localparam int unsigned SPLIT_W          = 11;
	localparam int unsigned STATUS_W         = 2;
	localparam int unsigned CFG_IDX_W        = 1;
	localparam int unsigned CFG_DATA_W       = 21;
	localparam int unsigned WORD_W           = 32;
	localparam int unsigned HEAP_BYTES_DEF   = 1048576;
	localparam int unsigned SIZE_CLASSES_DEF = 15;
	localparam int unsigned MIN_BLOCK        = 32;
	localparam int unsigned PROLOGUE_BYTES   = 16;
	localparam int unsigned SMALL_REQ        = 16;
	localparam int unsigned CHUNK_RESET      = 4096;
	localparam int unsigned SPLIT_RESET      = 32;

	localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OOM = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_IGN = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_EXTEND = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT  = 1'd1;

	// class bound i: fixed list, then doubling from 4096
	function automatic logic [31:0] class_bound(input int i);
		logic [31:0] b;
		case (i)
			0:       b = 32'd16;
			1:       b = 32'd32;
			2:       b = 32'd48;
			3:       b = 32'd64;
			4:       b = 32'd128;
			5:       b = 32'd192;
			6:       b = 32'd256;
			7:       b = 32'd384;
			8:       b = 32'd456;
			9:       b = 32'd512;
			10:      b = 32'd768;
			11:      b = 32'd1024;
			12:      b = 32'd1536;
			13:      b = 32'd2048;
			default: b = 32'd4096 << (i - 14);
		endcase
		return b;
	endfunction

	// number of the first ncls-1 bounds that size exceeds
	function automatic int unsigned class_of(input logic [31:0] size, input int unsigned ncls);
		int unsigned c;
		c = 0;
		for (int i = 0; i < 31; i++) begin
			if ((i + 1 < ncls) && (size > class_bound(i)))
				c++;
		end
		return c;
	endfunction

endpackage

FILE: design/segregated_fit_heap_allocator.sv
// Top level of the segregated-fit heap allocator: request sequencer around the heap RAM.
//
// A request (allocate or free) is taken when start is high and busy is low; exactly one
// result comes back later on result_addr/status, valid for the single cycle in which done
// is high, and the receiver cannot stall it. All work is serialized on the one heap RAM
// (one access per cycle, registered read data), so timing depends on heap contents: a
// zero-size allocate answers without leaving idle; an allocate visits each size class
// from the request's class upward and every free block on those lists (best fit walks
// them all), then grows the heap if needed, unlinks, splits and merges; a free walks each
// heap block from the heap start to the freed block (validity check), then merges and
// pushes. After reset the block stays busy while it writes the prologue and epilogue tags.
// Configuration writes (cfg_wr_en) take effect at once and are meant for idle periods.
module segregated_fit_heap_allocator #(
	parameter int unsigned HEAP_BYTES   = sfha_pkg::HEAP_BYTES_DEF,
	parameter int unsigned SIZE_CLASSES = sfha_pkg::SIZE_CLASSES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic [sfha_pkg::ADDR_W-1:0]     req_size,
	input  logic [sfha_pkg::ADDR_W-1:0]     block_addr,
	output logic                            done,
	output logic [sfha_pkg::ADDR_W-1:0]     result_addr,
	output logic [sfha_pkg::STATUS_W-1:0]   status,
	input  logic                            cfg_wr_en,
	input  logic [sfha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfha_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfha_pkg::*;

	localparam int unsigned HEAP_WORDS = HEAP_BYTES / 8;
	localparam int unsigned WI  = $clog2(HEAP_WORDS);
	// offsets and sizes: room for the heap end plus one grow step
	localparam int unsigned OW  = ($clog2(HEAP_BYTES) + 1 > ADDR_W + 1) ?
	                              $clog2(HEAP_BYTES) + 1 : ADDR_W + 1;
	localparam int unsigned CLW = $clog2(SIZE_CLASSES + 1);
	localparam int unsigned CIW = $clog2(SIZE_CLASSES);

	localparam logic [5:0] ST_INIT1  = 6'd0;
	localparam logic [5:0] ST_INIT2  = 6'd1;
	localparam logic [5:0] ST_INIT3  = 6'd2;
	localparam logic [5:0] ST_IDLE   = 6'd3;
	localparam logic [5:0] ST_A_CLS  = 6'd4;
	localparam logic [5:0] ST_S_CLS  = 6'd5;
	localparam logic [5:0] ST_S_NODE = 6'd6;
	localparam logic [5:0] ST_S_HDR  = 6'd7;
	localparam logic [5:0] ST_S_NEXT = 6'd8;
	localparam logic [5:0] ST_FIT    = 6'd9;
	localparam logic [5:0] ST_G_FT   = 6'd10;
	localparam logic [5:0] ST_G_EPI  = 6'd11;
	localparam logic [5:0] ST_PL     = 6'd12;
	localparam logic [5:0] ST_PL_TAG = 6'd13;
	localparam logic [5:0] ST_PL_AFT = 6'd14;
	localparam logic [5:0] ST_PL_RH  = 6'd15;
	localparam logic [5:0] ST_PL_RF  = 6'd16;
	localparam logic [5:0] ST_PL_FT  = 6'd17;
	localparam logic [5:0] ST_M_PF   = 6'd18;
	localparam logic [5:0] ST_M_NH   = 6'd19;
	localparam logic [5:0] ST_M_NX   = 6'd20;
	localparam logic [5:0] ST_M_PV   = 6'd21;
	localparam logic [5:0] ST_M_HD   = 6'd22;
	localparam logic [5:0] ST_M_FT   = 6'd23;
	localparam logic [5:0] ST_P_NX   = 6'd24;
	localparam logic [5:0] ST_P_PV   = 6'd25;
	localparam logic [5:0] ST_P_HD   = 6'd26;
	localparam logic [5:0] ST_U_NX   = 6'd27;
	localparam logic [5:0] ST_U_PV   = 6'd28;
	localparam logic [5:0] ST_U_LINK = 6'd29;
	localparam logic [5:0] ST_U_BACK = 6'd30;
	localparam logic [5:0] ST_W_HDR  = 6'd31;
	localparam logic [5:0] ST_W_CHK  = 6'd32;
	localparam logic [5:0] ST_F_HD   = 6'd33;
	localparam logic [5:0] ST_F_FT   = 6'd34;
	localparam logic [5:0] ST_OK     = 6'd35;

	function automatic logic [WI-1:0] wi(input logic [OW-1:0] off);
		return off[WI+2:3];
	endfunction

	function automatic logic [WORD_W-1:0] tag(input logic [OW-1:0] sz, input logic used);
		return WORD_W'(sz) | WORD_W'(used);
	endfunction

	// control
	logic [5:0]         state_q, ret_sub_q, ret_mrg_q;
	logic [OW-1:0]      brk_q;
	logic [OW-1:0]      heads_q [SIZE_CLASSES];
	logic [CHUNK_W-1:0] chunk_q;
	logic [SPLIT_W-1:0] split_q;
	logic               done_q;
	// working registers
	logic [OW-1:0]      bp_q, size_q, asize_q, best_q, best_size_q, cur_q;
	logic [OW-1:0]      ubp_q, usize_q, nx_q, pv_q, pft_q, head_q, addr_q, res_q;
	logic [CIW-1:0]     pcls_q;
	logic [CLW-1:0]     cls_q;
	logic [ADDR_W-1:0]  result_q;
	logic [STATUS_W-1:0] status_q;

	// heap RAM ports
	logic              mem_we, mem_re;
	logic [WI-1:0]     mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;

	sfha_ram #(.WIDTH(WORD_W), .DEPTH(HEAP_WORDS)) u_heap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// decoded read data, shared helpers
	logic [OW-1:0]  rd_link, rd_sz, pft_sz, cls_arg, head_rd, split_sz;
	logic [OW-1:0]  asize_in, ext_sz, esize, rem_sz;
	logic [OW:0]    grow_end;
	logic [CLW-1:0] cls_now;
	logic [CIW-1:0] head_idx;
	logic           do_split, best_hit;

	assign rd_link = mem_rdata[OW-1:0];
	assign rd_sz   = rd_link & ~OW'(7);
	assign pft_sz  = pft_q & ~OW'(7);
	assign rem_sz  = size_q - asize_q;

	// small split register acts as the minimum block
	assign split_sz = (OW'(split_q) < OW'(MIN_BLOCK)) ? OW'(MIN_BLOCK) : OW'(split_q);
	assign do_split = rem_sz >= split_sz;

	// block size for the request: header+footer overhead, 8-byte rounding
	assign asize_in = (OW'(req_size) <= OW'(SMALL_REQ)) ? OW'(MIN_BLOCK) :
	                  ((OW'(req_size) + OW'(SMALL_REQ + 7)) & ~OW'(7));

	// grow step: max(block, chunk), rounded down to words, then up to an even count
	assign ext_sz   = (asize_q > OW'(chunk_q)) ? asize_q : OW'(chunk_q);
	assign esize    = (OW'(ext_sz[OW-1:3]) + OW'(ext_sz[3])) << 3;
	assign grow_end = {1'b0, brk_q} + {1'b0, esize};

	assign best_hit = !mem_rdata[0] && (rd_sz >= asize_q) &&
	                  ((best_q == '0) || (rd_sz < best_size_q));

	// one class lookup, argument picked by state
	always_comb begin
		case (state_q)
			ST_U_LINK: cls_arg = usize_q;
			ST_P_NX:   cls_arg = size_q;
			default:   cls_arg = asize_q;
		endcase
	end
	assign cls_now  = CLW'(class_of(32'(cls_arg), SIZE_CLASSES));
	assign head_idx = (state_q == ST_P_NX) ? cls_now[CIW-1:0] : cls_q[CIW-1:0];
	assign head_rd  = heads_q[head_idx];

	// RAM access per state; reads and writes never share a cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			ST_INIT1: begin
				mem_we = 1'b1; mem_waddr = WI'(1); mem_wdata = tag(OW'(PROLOGUE_BYTES), 1'b1);
			end
			ST_INIT2: begin
				mem_we = 1'b1; mem_waddr = WI'(2); mem_wdata = tag(OW'(PROLOGUE_BYTES), 1'b1);
			end
			ST_INIT3: begin
				mem_we = 1'b1; mem_waddr = WI'(3); mem_wdata = tag('0, 1'b1);
			end
			ST_S_NODE: begin
				mem_re = (cur_q != '0); mem_raddr = wi(cur_q - OW'(8));
			end
			ST_S_HDR: begin
				mem_re = 1'b1; mem_raddr = wi(cur_q);
			end
			ST_FIT: begin
				mem_we    = (best_q == '0) && (grow_end <= (OW+1)'(HEAP_BYTES));
				mem_waddr = wi(brk_q - OW'(8));
				mem_wdata = tag(esize, 1'b0);
			end
			ST_G_FT: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q + size_q - OW'(16));
				mem_wdata = tag(size_q, 1'b0);
			end
			ST_G_EPI: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q + size_q - OW'(8)); mem_wdata = tag('0, 1'b1);
			end
			ST_PL_TAG: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q - OW'(8));
				mem_wdata = tag(do_split ? asize_q : size_q, 1'b1);
			end
			ST_PL_AFT: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q + asize_q - OW'(16));
				mem_wdata = tag(asize_q, 1'b1);
			end
			ST_PL_RH: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q + asize_q - OW'(8));
				mem_wdata = tag(rem_sz, 1'b0);
			end
			ST_PL_RF: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q + size_q - OW'(16));
				mem_wdata = tag(rem_sz, 1'b0);
			end
			ST_PL_FT: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q + size_q - OW'(16));
				mem_wdata = tag(size_q, 1'b1);
			end
			ST_M_PF: begin
				mem_re = 1'b1; mem_raddr = wi(bp_q - OW'(16));
			end
			ST_M_NH: begin
				mem_re = 1'b1; mem_raddr = wi(bp_q + size_q - OW'(8));
			end
			ST_M_HD, ST_F_HD: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q - OW'(8)); mem_wdata = tag(size_q, 1'b0);
			end
			ST_M_FT, ST_F_FT: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q + size_q - OW'(16));
				mem_wdata = tag(size_q, 1'b0);
			end
			ST_P_NX: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q); mem_wdata = WORD_W'(head_rd);
			end
			ST_P_PV: begin
				mem_we = 1'b1; mem_waddr = wi(bp_q + OW'(8)); mem_wdata = '0;
			end
			ST_P_HD: begin
				mem_we = (head_q != '0); mem_waddr = wi(head_q + OW'(8));
				mem_wdata = WORD_W'(bp_q);
			end
			ST_U_NX: begin
				mem_re = 1'b1; mem_raddr = wi(ubp_q);
			end
			ST_U_PV: begin
				mem_re = 1'b1; mem_raddr = wi(ubp_q + OW'(8));
			end
			ST_U_LINK: begin
				mem_we = (rd_link != '0); mem_waddr = wi(rd_link); mem_wdata = WORD_W'(nx_q);
			end
			ST_U_BACK: begin
				mem_we = (nx_q != '0); mem_waddr = wi(nx_q + OW'(8));
				mem_wdata = WORD_W'(pv_q);
			end
			ST_W_HDR: begin
				mem_re = (bp_q < brk_q); mem_raddr = wi(bp_q - OW'(8));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT1;
			ret_sub_q   <= ST_IDLE;
			ret_mrg_q   <= ST_IDLE;
			brk_q       <= OW'(MIN_BLOCK);
			for (int i = 0; i < SIZE_CLASSES; i++)
				heads_q[i] <= '0;
			chunk_q     <= CHUNK_W'(CHUNK_RESET);
			split_q     <= SPLIT_W'(SPLIT_RESET);
			done_q      <= 1'b0;
			bp_q        <= '0;
			size_q      <= '0;
			asize_q     <= '0;
			best_q      <= '0;
			best_size_q <= '0;
			cur_q       <= '0;
			ubp_q       <= '0;
			usize_q     <= '0;
			nx_q        <= '0;
			pv_q        <= '0;
			pft_q       <= '0;
			head_q      <= '0;
			addr_q      <= '0;
			res_q       <= '0;
			pcls_q      <= '0;
			cls_q       <= '0;
			result_q    <= '0;
			status_q    <= STAT_OK;
		end else begin
			done_q <= 1'b0;

			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_EXTEND: chunk_q <= cfg_data[CHUNK_W-1:0];
					CFG_SPLIT:  split_q <= cfg_data[SPLIT_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_INIT1: state_q <= ST_INIT2;
				ST_INIT2: state_q <= ST_INIT3;
				ST_INIT3: state_q <= ST_IDLE;
				ST_IDLE: begin
					if (start) begin
						res_q  <= '0;
						addr_q <= OW'(block_addr);
						if (req_type == REQ_FREE) begin
							bp_q    <= OW'(MIN_BLOCK);
							state_q <= ST_W_HDR;
						end else if (req_size == '0) begin
							done_q   <= 1'b1;
							result_q <= '0;
							status_q <= STAT_IGN;
						end else begin
							asize_q <= asize_in;
							state_q <= ST_A_CLS;
						end
					end
				end
				// best fit scan
				ST_A_CLS: begin
					cls_q   <= cls_now;
					best_q  <= '0;
					state_q <= ST_S_CLS;
				end
				ST_S_CLS: begin
					if (cls_q == CLW'(SIZE_CLASSES)) begin
						state_q <= ST_FIT;
					end else begin
						cur_q   <= head_rd;
						state_q <= ST_S_NODE;
					end
				end
				ST_S_NODE: begin
					if (cur_q == '0) begin
						cls_q   <= cls_q + CLW'(1);
						state_q <= ST_S_CLS;
					end else begin
						state_q <= ST_S_HDR;
					end
				end
				ST_S_HDR: begin
					if (best_hit) begin
						best_q      <= cur_q;
						best_size_q <= rd_sz;
					end
					state_q <= ST_S_NEXT;
				end
				ST_S_NEXT: begin
					cur_q   <= rd_link;
					state_q <= ST_S_NODE;
				end
				ST_FIT: begin
					if (best_q != '0) begin
						bp_q    <= best_q;
						size_q  <= best_size_q;
						state_q <= ST_PL;
					end else if (grow_end > (OW+1)'(HEAP_BYTES)) begin
						done_q   <= 1'b1;
						result_q <= '0;
						status_q <= STAT_OOM;
						state_q  <= ST_IDLE;
					end else begin
						bp_q    <= brk_q;
						size_q  <= esize;
						brk_q   <= grow_end[OW-1:0];
						state_q <= ST_G_FT;
					end
				end
				ST_G_FT: state_q <= ST_G_EPI;
				ST_G_EPI: begin
					ret_mrg_q <= ST_PL;
					state_q   <= ST_M_PF;
				end
				// place: unlink, tag, maybe split and merge the rest
				ST_PL: begin
					res_q     <= bp_q;
					ubp_q     <= bp_q;
					usize_q   <= size_q;
					ret_sub_q <= ST_PL_TAG;
					state_q   <= ST_U_NX;
				end
				ST_PL_TAG: state_q <= do_split ? ST_PL_AFT : ST_PL_FT;
				ST_PL_AFT: state_q <= ST_PL_RH;
				ST_PL_RH:  state_q <= ST_PL_RF;
				ST_PL_RF: begin
					bp_q      <= bp_q + asize_q;
					size_q    <= rem_sz;
					ret_mrg_q <= ST_OK;
					state_q   <= ST_M_PF;
				end
				ST_PL_FT: state_q <= ST_OK;
				// merge with free neighbors, then push
				ST_M_PF: state_q <= ST_M_NH;
				ST_M_NH: begin
					pft_q   <= rd_link;
					state_q <= ST_M_NX;
				end
				ST_M_NX: begin
					if (!mem_rdata[0]) begin
						ubp_q     <= bp_q + size_q;
						usize_q   <= rd_sz;
						size_q    <= size_q + rd_sz;
						ret_sub_q <= ST_M_PV;
						state_q   <= ST_U_NX;
					end else begin
						state_q <= ST_M_PV;
					end
				end
				ST_M_PV: begin
					if (!pft_q[0]) begin
						ubp_q     <= bp_q - pft_sz;
						usize_q   <= pft_sz;
						size_q    <= size_q + pft_sz;
						bp_q      <= bp_q - pft_sz;
						ret_sub_q <= ST_M_HD;
						state_q   <= ST_U_NX;
					end else begin
						state_q <= ST_M_HD;
					end
				end
				ST_M_HD: state_q <= ST_M_FT;
				ST_M_FT: begin
					ret_sub_q <= ret_mrg_q;
					state_q   <= ST_P_NX;
				end
				// LIFO push onto the class list
				ST_P_NX: begin
					head_q  <= head_rd;
					pcls_q  <= cls_now[CIW-1:0];
					state_q <= ST_P_PV;
				end
				ST_P_PV: state_q <= ST_P_HD;
				ST_P_HD: begin
					heads_q[pcls_q] <= bp_q;
					state_q         <= ret_sub_q;
				end
				// unlink ubp_q from its list
				ST_U_NX: state_q <= ST_U_PV;
				ST_U_PV: begin
					nx_q    <= rd_link;
					state_q <= ST_U_LINK;
				end
				ST_U_LINK: begin
					pv_q <= rd_link;
					if (rd_link == '0)
						heads_q[cls_now[CIW-1:0]] <= nx_q;
					state_q <= ST_U_BACK;
				end
				ST_U_BACK: state_q <= ret_sub_q;
				// free: walk blocks to validate the address
				ST_W_HDR: begin
					if (bp_q < brk_q) begin
						state_q <= ST_W_CHK;
					end else begin
						done_q   <= 1'b1;
						result_q <= '0;
						status_q <= STAT_IGN;
						state_q  <= ST_IDLE;
					end
				end
				ST_W_CHK: begin
					if ((rd_sz == '0) || (bp_q > addr_q) ||
					    ((bp_q == addr_q) && !mem_rdata[0])) begin
						done_q   <= 1'b1;
						result_q <= '0;
						status_q <= STAT_IGN;
						state_q  <= ST_IDLE;
					end else if (bp_q == addr_q) begin
						size_q  <= rd_sz;
						state_q <= ST_F_HD;
					end else begin
						bp_q    <= bp_q + rd_sz;
						state_q <= ST_W_HDR;
					end
				end
				ST_F_HD: state_q <= ST_F_FT;
				ST_F_FT: begin
					ret_mrg_q <= ST_OK;
					state_q   <= ST_M_PF;
				end
				ST_OK: begin
					done_q   <= 1'b1;
					result_q <= res_q[ADDR_W-1:0];
					status_q <= STAT_OK;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign result_addr = result_q;
	assign status      = status_q;

	// break moves in 16-byte steps and never passes the heap end
	a_brk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(brk_q[3:0] == 4'd0) && (brk_q <= OW'(HEAP_BYTES)))
		else $error("break out of range");

	// failed or ignored requests return no address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != STAT_OK) |-> (result_q == '0))
		else $error("address on failed request");

	// payload offsets are word aligned
	a_res_align: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (result_q[2:0] == 3'd0))
		else $error("misaligned result");

	// sequencer never reads and writes the heap in one cycle
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("heap read and write collide");

endmodule

FILE: design/sfha_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sfha_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

FILE: sim/tb.sv
// Self-checking testbench for the segregated-fit heap allocator.
`timescale 1ns / 100ps

module tb;
	import sfha_pkg::*;

	localparam int unsigned HEAP_SIZE   = 1048576;
	localparam int unsigned HEAP_WORDS  = HEAP_SIZE / 8;
	localparam int unsigned NUM_CLASSES = 15;
	localparam int unsigned CYCLE_LIMIT = 6000000;
	localparam int unsigned DIR_ROWS    = 22;
	localparam int unsigned NUM_PHASES  = 8;
	localparam int unsigned PHASE_ITEMS = 125;

	// size-class bounds; only the first NUM_CLASSES-1 are used
	localparam bit [31:0] CLASS_LIMITS [0:13] = '{16, 32, 48, 64, 128, 192, 256, 384,
		456, 512, 768, 1024, 1536, 2048};

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  req_type;
	logic [ADDR_W-1:0]     req_size;
	logic [ADDR_W-1:0]     block_addr;
	logic                  done;
	logic [ADDR_W-1:0]     result_addr;
	logic [STATUS_W-1:0]   status;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	segregated_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .req_size(req_size), .block_addr(block_addr),
		.done(done), .result_addr(result_addr), .status(status),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// Allocator shadow: heap words, free-list heads, break, registers
	// ---------------------------------------------------------------
	bit [31:0] heap_mem [0:HEAP_WORDS-1];
	bit [31:0] free_heads [0:NUM_CLASSES-1];
	bit [31:0] heap_brk;
	bit [31:0] chunk_reg;
	bit [31:0] split_reg;

	typedef struct {
		logic [ADDR_W-1:0]   addr;
		logic [STATUS_W-1:0] stat;
	} outcome_t;

	outcome_t  pending_results [$];
	bit [31:0] live_blocks [$];   // payload offsets currently allocated
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned n_alloc, n_free, n_oom, n_ign;

	function automatic bit [31:0] hw_rd(bit [31:0] off);
		bit [31:0] idx;
		idx = off >> 3;
		return (idx < HEAP_WORDS) ? heap_mem[idx] : 32'd0;
	endfunction

	function automatic void hw_wr(bit [31:0] off, bit [31:0] v);
		bit [31:0] idx;
		idx = off >> 3;
		if (idx < HEAP_WORDS)
			heap_mem[idx] = v;
	endfunction

	function automatic bit [31:0] tag_size(bit [31:0] bp);
		return hw_rd(bp - 8) & ~32'd7;
	endfunction

	function automatic void put_tags(bit [31:0] bp, bit [31:0] sz, bit used);
		hw_wr(bp - 8, sz | used);
		hw_wr(bp + sz - 16, sz | used);
	endfunction

	function automatic int unsigned size_class(bit [31:0] sz);
		int unsigned c;
		c = 0;
		for (int i = 0; i < NUM_CLASSES - 1; i++)
			if (sz > CLASS_LIMITS[i])
				c++;
		return c;
	endfunction

	function automatic void list_insert(bit [31:0] bp);
		int unsigned c;
		bit [31:0] head;
		c = size_class(tag_size(bp));
		head = free_heads[c];
		hw_wr(bp, head);
		hw_wr(bp + 8, 0);
		if (head != 0)
			hw_wr(head + 8, bp);
		free_heads[c] = bp;
	endfunction

	function automatic void list_remove(bit [31:0] bp);
		int unsigned c;
		bit [31:0] nx, pv;
		c = size_class(tag_size(bp));
		nx = hw_rd(bp);
		pv = hw_rd(bp + 8);
		if (pv == 0)
			free_heads[c] = nx;
		else
			hw_wr(pv, nx);
		if (nx != 0)
			hw_wr(nx + 8, pv);
	endfunction

	// merge with free neighbors, then push on its class list
	function automatic bit [31:0] coalesce(bit [31:0] bp);
		bit [31:0] sz, nb, prev_tag, next_tag, ps;
		sz = tag_size(bp);
		prev_tag = hw_rd(bp - 16);
		nb = bp + sz;
		next_tag = hw_rd(nb - 8);
		if (!next_tag[0]) begin
			list_remove(nb);
			sz += tag_size(nb);
		end
		if (!prev_tag[0]) begin
			ps = prev_tag & ~32'd7;
			list_remove(bp - ps);
			sz += ps;
			bp -= ps;
		end
		put_tags(bp, sz, 1'b0);
		list_insert(bp);
		return bp;
	endfunction

	function automatic void carve(bit [31:0] bp, bit [31:0] asize);
		bit [31:0] csize, thr, rest;
		csize = tag_size(bp);
		thr = (split_reg < MIN_BLOCK) ? MIN_BLOCK : split_reg;
		list_remove(bp);
		if (csize - asize >= thr) begin
			put_tags(bp, asize, 1'b1);
			put_tags(bp + asize, csize - asize, 1'b0);
			rest = coalesce(bp + asize);
		end else begin
			put_tags(bp, csize, 1'b1);
		end
	endfunction

	function automatic bit [31:0] find_best(bit [31:0] asize);
		bit [31:0] best, best_sz, bp, s, hdr;
		int unsigned guard;
		best = 0;
		best_sz = 0;
		for (int c = size_class(asize); c < NUM_CLASSES; c++) begin
			bp = free_heads[c];
			guard = 0;
			while (bp != 0 && guard < HEAP_WORDS) begin
				s = tag_size(bp);
				hdr = hw_rd(bp - 8);
				if (!hdr[0] && s >= asize && (best == 0 || s < best_sz)) begin
					best = bp;
					best_sz = s;
				end
				bp = hw_rd(bp);
				guard++;
			end
		end
		return best;
	endfunction

	function automatic bit is_live_block(bit [31:0] addr);
		bit [31:0] bp, s, hdr;
		bp = MIN_BLOCK;
		while (bp < heap_brk) begin
			s = tag_size(bp);
			if (s == 0)
				return 1'b0;
			if (bp == addr) begin
				hdr = hw_rd(bp - 8);
				return hdr[0];
			end
			if (bp > addr)
				return 1'b0;
			bp += s;
		end
		return 1'b0;
	endfunction

	function automatic outcome_t heap_request(bit kind, bit [31:0] sz, bit [31:0] addr);
		outcome_t r;
		bit [31:0] asize, bp, ext, words, esize;
		r.addr = '0;
		r.stat = STAT_OK;
		if (kind == REQ_ALLOC) begin
			if (sz == 0) begin
				r.stat = STAT_IGN;
			end else begin
				asize = (sz <= SMALL_REQ) ? MIN_BLOCK : ((sz + 23) & ~32'd7);
				bp = find_best(asize);
				if (bp == 0) begin
					ext = (asize > chunk_reg) ? asize : chunk_reg;
					words = ext >> 3;
					if (words[0])
						words++;
					esize = words * 8;
					if (64'(heap_brk) + 64'(esize) > 64'(HEAP_SIZE)) begin
						r.stat = STAT_OOM;
					end else begin
						bp = heap_brk;
						heap_brk += esize;
						put_tags(bp, esize, 1'b0);
						hw_wr(bp + esize - 8, 1);
						bp = coalesce(bp);
					end
				end
				if (bp != 0) begin
					carve(bp, asize);
					r.addr = bp[ADDR_W-1:0];
				end
			end
		end else if (is_live_block(addr)) begin
			put_tags(addr, tag_size(addr), 1'b0);
			bp = coalesce(addr);
		end else begin
			r.stat = STAT_IGN;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Result checker: done strobes cannot be held off, compare in order
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: addr %0d status %0d",
					result_addr, status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (result_addr !== want.addr) begin
					$error("result_addr: expected %0d, got %0d", want.addr, result_addr);
					mismatches++;
				end
				if (status !== want.stat) begin
					$error("status: expected %0d, got %0d", want.stat, status);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// present one item after an optional gap; returns once it is taken
	task automatic issue(input bit kind, input bit [31:0] sz, input bit [31:0] addr,
		input int unsigned gap, input bit known, input outcome_t typed);
		outcome_t r;
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_type   = kind;
		req_size   = sz[ADDR_W-1:0];
		block_addr = addr[ADDR_W-1:0];
		start      = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		// taken at this edge: update shadow and queue what must come back
		r = heap_request(kind, {11'd0, sz[ADDR_W-1:0]}, {11'd0, addr[ADDR_W-1:0]});
		pending_results.push_back(known ? typed : r);
		if (kind == REQ_ALLOC) begin
			n_alloc++;
			if (r.stat == STAT_OK && r.addr != 0)
				live_blocks.push_back({11'd0, r.addr});
		end else begin
			n_free++;
			if (r.stat == STAT_OK)
				foreach (live_blocks[i])
					if (live_blocks[i] == addr) begin
						live_blocks.delete(i);
						break;
					end
		end
		if (r.stat == STAT_OOM)
			n_oom++;
		if (r.stat == STAT_IGN)
			n_ign++;
	endtask

	// drain all outstanding results, then wait for the block to go idle
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
	endtask

	task automatic write_regs(input bit [31:0] chunk, input bit [31:0] split);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = CFG_EXTEND;
		cfg_data  = chunk[CFG_DATA_W-1:0];
		chunk_reg = chunk & 32'h1FFFFF;
		@(negedge clk);
		cfg_index = CFG_SPLIT;
		cfg_data  = split[CFG_DATA_W-1:0];
		split_reg = split & 32'h7FF;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	function automatic bit [31:0] pick_size();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 3)
			return 0;
		if (sel < 30)
			return $urandom_range(1, 16);
		if (sel < 75)
			return $urandom_range(17, 600);
		if (sel < 95)
			return $urandom_range(601, 6000);
		if (sel < 98)
			return $urandom_range(6001, 70000);
		return $urandom & 32'h1FFFFF;   // mostly out of memory, flips high bits
	endfunction

	// ---------------------------------------------------------------
	// Directed rows; typed results only where obvious
	// ---------------------------------------------------------------
	typedef struct {
		bit          kind;
		bit [31:0]   sz;
		bit [31:0]   addr;
		bit          known;
		bit [31:0]   ea;
		bit [1:0]    es;
	} dir_row_t;

	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{REQ_ALLOC, 1,       0,       1, 32, STAT_OK},   // first grow of the heap
		'{REQ_ALLOC, 0,       0,       1, 0,  STAT_IGN},  // zero size
		'{REQ_ALLOC, 16,      0,       1, 64, STAT_OK},
		'{REQ_ALLOC, 17,      0,       1, 96, STAT_OK},
		'{REQ_FREE,  0,       5,       1, 0,  STAT_IGN},  // stray address
		'{REQ_FREE,  0,       100,     1, 0,  STAT_IGN},  // inside a block
		'{REQ_FREE,  0,       32,      1, 0,  STAT_OK},
		'{REQ_FREE,  0,       32,      1, 0,  STAT_IGN},  // double free
		'{REQ_ALLOC, 1048576, 0,       1, 0,  STAT_OOM},
		'{REQ_ALLOC, 2097151, 0,       1, 0,  STAT_OOM},
		'{REQ_FREE,  2097151, 2097151, 1, 0,  STAT_IGN},
		'{REQ_FREE,  0,       0,       1, 0,  STAT_IGN},
		'{REQ_ALLOC, 24,      0,       0, 0,  STAT_OK},
		'{REQ_ALLOC, 4000,    0,       0, 0,  STAT_OK},   // grows, merges with tail
		'{REQ_FREE,  0,       96,      0, 0,  STAT_OK},
		'{REQ_FREE,  0,       64,      0, 0,  STAT_OK},   // merges both sides
		'{REQ_ALLOC, 200,     0,       0, 0,  STAT_OK},
		'{REQ_ALLOC, 500,     0,       0, 0,  STAT_OK},
		'{REQ_ALLOC, 1500,    0,       0, 0,  STAT_OK},
		'{REQ_ALLOC, 3000,    0,       0, 0,  STAT_OK},
		'{REQ_ALLOC, 1048575, 0,       0, 0,  STAT_OOM},
		'{REQ_ALLOC, 40,      0,       0, 0,  STAT_OK}
	};

	// register settings per random phase: extremes first, then mid and random
	bit [31:0] phase_chunk [0:NUM_PHASES-1];
	bit [31:0] phase_split [0:NUM_PHASES-1];

	initial begin
		outcome_t  typed;
		bit        kind;
		bit [31:0] sz, addr;
		int unsigned gap, sel;
		bit        last_part;

		// drive everything known before reset releases
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = REQ_ALLOC;
		req_size   = '0;
		block_addr = '0;
		cfg_wr_en  = 1'b0;
		cfg_index  = CFG_EXTEND;
		cfg_data   = '0;
		mismatches = 0;
		cycles     = 0;
		n_alloc = 0; n_free = 0; n_oom = 0; n_ign = 0;

		// shadow reset: prologue and epilogue tags
		foreach (heap_mem[i])
			heap_mem[i] = 0;
		foreach (free_heads[i])
			free_heads[i] = 0;
		heap_mem[1] = 32'd17;
		heap_mem[2] = 32'd17;
		heap_mem[3] = 32'd1;
		heap_brk  = 32;
		chunk_reg = CHUNK_RESET;
		split_reg = SPLIT_RESET;

		phase_chunk = '{32, 1048576, 4096, 64, 0, 0, 8192, 4096};
		phase_split = '{0, 1024, 32, 16, 0, 0, 200, 32};
		for (int p = 4; p < 6; p++) begin
			phase_chunk[p] = $urandom_range(32, 20000);
			phase_split[p] = $urandom_range(0, 1024);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under reset register values
		for (int i = 0; i < DIR_ROWS; i++) begin
			typed.addr = dir_rows[i].ea[ADDR_W-1:0];
			typed.stat = dir_rows[i].es;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
			issue(dir_rows[i].kind, dir_rows[i].sz, dir_rows[i].addr, gap,
				dir_rows[i].known, typed);
		end

		// random phases; each register change waits for a fully idle block
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_regs(phase_chunk[p], phase_split[p]);
			last_part = (p == NUM_PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				addr = $urandom & 32'h1FFFFF;
				sz   = $urandom & 32'h1FFFFF;
				// lean toward frees when many blocks are live
				if (live_blocks.size() > 150)
					sel = sel / 2 + 45;
				if (sel < 55) begin
					kind = REQ_ALLOC;
					sz   = pick_size();
				end else if (sel < 90 && live_blocks.size() != 0) begin
					kind = REQ_FREE;
					addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
				end else begin
					// noise: stray, off by one to four words or already freed addresses
					kind = REQ_FREE;
					if (live_blocks.size() != 0 && $urandom_range(0, 1))
						addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)]
							+ 8 * $urandom_range(1, 4);
				end
				// bursty idling, none in the closing phase
				gap = 0;
				if (!last_part && $urandom_range(0, 9) < 3 && (n / 20) % 2 == 0)
					gap = $urandom_range(1, 12);
				issue(kind, sz, addr, gap, 1'b0, typed);
			end
		end

		drain();
		repeat (50) @(posedge clk);

		$display("covered %0d allocates and %0d frees over %0d register settings",
			n_alloc, n_free, NUM_PHASES + 1);
		$display("%0d out-of-memory and %0d ignored requests, %0d blocks still live",
			n_oom, n_ign, live_blocks.size());
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/sfha_pkg.sv
design/sfha_ram.sv
design/segregated_fit_heap_allocator.sv
sim/tb.sv
